[sv/ctfd_pkg.sv]
package ctfd_pkg;

  // input action codes
  localparam logic ACTION_BYTE  = 1'b0;
  localparam logic ACTION_CLEAR = 1'b1;

  // frame header layout
  localparam logic [2:0] HEADER_BYTES = 3'd5;
  localparam logic [7:0] CHANNEL_MAX   = 8'd5;
  localparam logic [7:0] CHANNEL_EXIT  = 8'd3;
  localparam logic [7:0] CHANNEL_CLOSE = 8'd4;

  // error codes
  localparam logic [1:0] ERR_UNKNOWN_CHANNEL  = 2'd0;
  localparam logic [1:0] ERR_BAD_CONTROL_SIZE = 2'd1;
  localparam logic [1:0] ERR_TOO_LARGE        = 2'd2;

  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65535;

  // depth of the item queue and of the result queue (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    KIND_BYTE,
    KIND_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [2:0] channel;
    logic [7:0] data_out;
    logic       payload_valid;
    logic       frame_last;
    logic       error;
    logic [1:0] error_code;
  } res_t;

endpackage

[sv/ctfd_front.sv]
module ctfd_front import ctfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       action,
  input  logic [7:0] data_in,
  output logic       item_valid,
  output item_t      item,
  input  logic       item_take
);

  item_t             slot [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  item_t             new_item;
  logic              do_push;
  logic              do_pop;

  // classify the incoming item
  always_comb begin
    new_item.data = data_in;
    unique case (action)
      ACTION_BYTE:  new_item.kind = KIND_BYTE;
      ACTION_CLEAR: new_item.kind = KIND_CLEAR;
      default:      new_item.kind = KIND_BYTE;
    endcase
  end

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign item_valid = (count != '0);
  assign item       = slot[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= new_item;
  end

endmodule

[sv/ctfd_core.sv]
module ctfd_core import ctfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [31:0] cfg_data,
  input  logic        item_valid,
  input  item_t       item,
  output logic        item_take,
  input  logic        room,
  output logic        res_valid,
  output res_t        res
);

  logic [31:0] max_payload;
  logic [2:0]  header_count, header_count_next;
  logic [7:0]  channel_id, channel_id_next;
  logic [31:0] length_accum, length_accum_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic        in_payload, in_payload_next;
  logic        error_flag, error_flag_next;
  logic [1:0]  error_kind, error_kind_next;

  logic [31:0] full_len;
  logic [2:0]  hc_plus;
  logic [1:0]  byte_slot;
  logic        fail;
  logic [1:0]  fail_code;

  assign item_take = item_valid && room;

  assign byte_slot = header_count[1:0] - 2'd1;
  assign full_len  = length_accum | ({24'd0, item.data} << {byte_slot, 3'b000});
  assign hc_plus   = header_count + 3'd1;

  // header checks, in priority order
  always_comb begin
    fail      = 1'b1;
    fail_code = ERR_UNKNOWN_CHANNEL;
    priority if (channel_id > CHANNEL_MAX) begin
      fail_code = ERR_UNKNOWN_CHANNEL;
    end else if ((channel_id == CHANNEL_EXIT && full_len != 32'd1) ||
                 (channel_id == CHANNEL_CLOSE && full_len != 32'd0)) begin
      fail_code = ERR_BAD_CONTROL_SIZE;
    end else if (full_len > max_payload) begin
      fail_code = ERR_TOO_LARGE;
    end else begin
      fail = 1'b0;
    end
  end

  always_comb begin
    header_count_next    = header_count;
    channel_id_next      = channel_id;
    length_accum_next    = length_accum;
    bytes_remaining_next = bytes_remaining;
    in_payload_next      = in_payload;
    error_flag_next      = error_flag;
    error_kind_next      = error_kind;
    res_valid            = 1'b0;
    res                  = '0;

    if (item_take) begin
      unique case (item.kind)
        KIND_CLEAR: begin
          header_count_next    = '0;
          channel_id_next      = '0;
          length_accum_next    = '0;
          bytes_remaining_next = '0;
          in_payload_next      = 1'b0;
          error_flag_next      = 1'b0;
          error_kind_next      = '0;
        end
        KIND_BYTE: begin
          priority if (error_flag) begin
            res_valid      = 1'b1;
            res.error      = 1'b1;
            res.error_code = error_kind;
          end else if (in_payload) begin
            bytes_remaining_next = bytes_remaining - 32'd1;
            res_valid            = 1'b1;
            res.channel          = channel_id[2:0];
            res.data_out         = item.data;
            res.payload_valid    = 1'b1;
            res.frame_last       = (bytes_remaining == 32'd1);
            if (bytes_remaining == 32'd1) in_payload_next = 1'b0;
          end else if (header_count == 3'd0) begin
            channel_id_next   = item.data;
            length_accum_next = '0;
            header_count_next = 3'd1;
          end else begin
            length_accum_next = full_len;
            header_count_next = hc_plus;
            if (hc_plus == HEADER_BYTES) begin
              header_count_next = '0;
              if (fail) begin
                error_flag_next      = 1'b1;
                error_kind_next      = fail_code;
                in_payload_next      = 1'b0;
                bytes_remaining_next = '0;
                res_valid            = 1'b1;
                res.error            = 1'b1;
                res.error_code       = fail_code;
              end else if (full_len == 32'd0) begin
                // empty frame marker
                res_valid      = 1'b1;
                res.channel    = channel_id[2:0];
                res.frame_last = 1'b1;
              end else begin
                bytes_remaining_next = full_len;
                in_payload_next      = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload     <= MAX_PAYLOAD_RESET;
      header_count    <= '0;
      channel_id      <= '0;
      length_accum    <= '0;
      bytes_remaining <= '0;
      in_payload      <= 1'b0;
      error_flag      <= 1'b0;
      error_kind      <= '0;
    end else begin
      if (cfg_valid) max_payload <= cfg_data;
      header_count    <= header_count_next;
      channel_id      <= channel_id_next;
      length_accum    <= length_accum_next;
      bytes_remaining <= bytes_remaining_next;
      in_payload      <= in_payload_next;
      error_flag      <= error_flag_next;
      error_kind      <= error_kind_next;
    end
  end

endmodule

[sv/ctfd_outq.sv]
module ctfd_outq import ctfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic res_valid,
  input  res_t res,
  output logic room,
  output logic empty,
  input  logic pop,
  output res_t head
);

  res_t              slot [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign room    = (count != CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head    = slot[rd_ptr];
  assign do_push = res_valid && room;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= res;
  end

endmodule

[sv/channel_tagged_frame_deframer.sv]
// channel    direction  handshake                 payload
// input      in         push / full               action, data_in
// result     out        pop / empty               channel, data_out, payload_valid,
//                                                 frame_last, error, error_code
// config     in         cfg_valid / cfg_ready     cfg_data (max_payload)
//
// one byte per cycle sustained while the result queue has room; a pushed byte is registered in an
// item queue slot, then the decoder writes its result into the result queue
// the decoder advances one item per cycle while the result queue has a free slot
// rst is synchronous, active high; max_payload resets to 65535, decoder state to zero
// full rises only when the item queue holds two items; empty stays low while results wait
module channel_tagged_frame_deframer import ctfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // item side
  input  logic        push,
  output logic        full,
  input  logic        action,
  input  logic [7:0]  data_in,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  channel,
  output logic [7:0]  data_out,
  output logic        payload_valid,
  output logic        frame_last,
  output logic        error,
  output logic [1:0]  error_code,
  // max_payload write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  item_t item;
  logic  item_valid;
  logic  item_take;
  logic  room;
  logic  res_valid;
  res_t  res;
  res_t  head;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // front: accepts and classifies items into a short queue
  ctfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .data_in    (data_in),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // back: header assembly, checks, payload counting, sticky error
  ctfd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .room       (room),
    .res_valid  (res_valid),
    .res        (res)
  );

  // results wait here until popped
  ctfd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .room      (room),
    .empty     (empty),
    .pop       (pop),
    .head      (head)
  );

  assign channel       = head.channel;
  assign data_out      = head.data_out;
  assign payload_valid = head.payload_valid;
  assign frame_last    = head.frame_last;
  assign error         = head.error;
  assign error_code    = head.error_code;

endmodule
